// ===== sv/csl_pkg.sv =====
// types, codes and helper functions shared by the c string literal decoder
// no dependencies; compile first

package csl_pkg;

    localparam int UNIT_BITS = 16;
    localparam int ACC_BITS  = 32;
    localparam int MAX_RES   = 3;

    typedef logic [UNIT_BITS-1:0] unit_t;

    typedef enum logic [3:0] {
        PH_SEEK,
        PH_LIT,
        PH_ESC,
        PH_OCT,
        PH_HEXSTART,
        PH_HEX,
        PH_UCN,
        PH_UCNBAD,
        PH_BETWEEN,
        PH_STOPPED,
        PH_DONE
    } phase_t;

    typedef enum logic [2:0] {
        ST_OK          = 3'd0,
        ST_NO_QUOTE    = 3'd1,
        ST_END_ESC     = 3'd2,
        ST_EMPTY_HEX   = 3'd3,
        ST_SHORT_UCN   = 3'd4,
        ST_BAD_UCN     = 3'd5,
        ST_UNTERM      = 3'd6,
        ST_NOTHING     = 3'd7
    } status_t;

    typedef struct packed {
        unit_t       unit;
        logic        unknown;
        logic        is_status;
        logic [2:0]  status;
        logic        last;
    } res_t;

    typedef struct packed {
        logic [1:0]           count;
        res_t [MAX_RES-1:0]   slot;
    } batch_t;

    localparam unit_t CH_QUOTE = 16'h0022;
    localparam unit_t CH_BSL   = 16'h005C;

    function automatic res_t mk_data(unit_t u, logic unk);
        res_t r;
        r = '0;
        r.unit = u;
        r.unknown = unk;
        return r;
    endfunction

    function automatic res_t mk_status(status_t st);
        res_t r;
        r = '0;
        r.is_status = 1'b1;
        r.status = st;
        return r;
    endfunction

    // bit 4 flags a valid hex digit, low nibble is its value
    function automatic logic [4:0] hex_digit(unit_t c);
        logic [4:0] r;
        r = '0;
        if (c >= 16'h0030 && c <= 16'h0039)
            r = {1'b1, c[3:0]};
        else if ((c >= 16'h0061 && c <= 16'h0066) || (c >= 16'h0041 && c <= 16'h0046))
            r = {1'b1, c[3:0] + 4'd9};
        return r;
    endfunction

    function automatic logic is_space(unit_t c);
        return (c == 16'h0020) || (c >= 16'h0009 && c <= 16'h000D);
    endfunction

endpackage

// ===== sv/csl_in_if.sv =====
// input channel: one code unit of the text per item
// depends on csl_pkg

interface csl_in_if;
    logic                 valid;
    logic                 ready;
    csl_pkg::unit_t       code_unit;
    logic                 end_of_text;

    modport source (output valid, output code_unit, output end_of_text, input ready);
    modport sink   (input valid, input code_unit, input end_of_text, output ready);
endinterface

// ===== sv/csl_out_if.sv =====
// output channel: one decoded unit or the final status per item
// depends on csl_pkg

interface csl_out_if;
    logic                 valid;
    logic                 ready;
    csl_pkg::unit_t       decoded_unit;
    logic                 unknown_escape;
    logic                 is_status;
    logic [2:0]           status;
    logic                 last_of_item;

    modport source (output valid, output decoded_unit, output unknown_escape,
                    output is_status, output status, output last_of_item, input ready);
    modport sink   (input valid, input decoded_unit, input unknown_escape,
                    input is_status, input status, input last_of_item, output ready);
endinterface

// ===== sv/csl_decode.sv =====
// parser state registers and the single-step decode of one code unit
// produces up to three results per unit; depends on csl_pkg

module csl_decode (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            fire,
    input  csl_pkg::unit_t  code_unit,
    input  logic            end_of_text,
    output csl_pkg::batch_t batch
);
    import csl_pkg::*;

    phase_t               ph_reg, ph_next;
    logic [ACC_BITS-1:0]  acc_reg, acc_next;
    logic [3:0]           dc_reg, dc_next;
    logic                 lu_reg, lu_next;
    logic                 ea_reg, ea_next;
    logic                 sqp_reg, sqp_next;
    logic                 pwq_reg, pwq_next;

    logic [1:0]           n;
    logic [3:0]           need;
    logic [4:0]           hx;
    logic                 is_q;
    logic                 is_oct;
    logic                 data_put;
    logic                 emitted;
    phase_t               lit_ph;
    logic                 lit_put;
    logic [ACC_BITS-1:0]  ucn_v;

    always_comb
    begin
        ph_next  = ph_reg;
        acc_next = acc_reg;
        dc_next  = dc_reg;
        lu_next  = lu_reg;
        sqp_next = sqp_reg;
        batch    = '0;
        n        = 2'd0;
        data_put = 1'b0;
        need     = lu_reg ? 4'd8 : 4'd4;
        hx       = hex_digit(code_unit);
        is_q     = (code_unit == CH_QUOTE);
        is_oct   = (code_unit >= 16'h0030 && code_unit <= 16'h0037);
        ucn_v    = acc_reg - 32'h0001_0000;

        if (is_q && pwq_reg)
            sqp_next = 1'b1;
        pwq_next = is_q;

        // ordinary literal character handling
        lit_put = 1'b0;
        if (is_q)
            lit_ph = PH_BETWEEN;
        else if (code_unit == CH_BSL)
            lit_ph = PH_ESC;
        else
        begin
            lit_ph = PH_LIT;
            lit_put = 1'b1;
        end

        unique case (ph_reg)
            PH_SEEK:
            begin
                if (is_q)
                    ph_next = PH_LIT;
            end
            PH_LIT:
            begin
                ph_next = lit_ph;
                if (lit_put)
                begin
                    batch.slot[n] = mk_data(code_unit, 1'b0);
                    n = n + 2'd1;
                end
            end
            PH_ESC:
            begin
                ph_next = PH_LIT;
                case (code_unit)
                    16'h005C, 16'h0022:
                    begin
                        batch.slot[n] = mk_data(code_unit, 1'b0);
                        n = n + 2'd1;
                    end
                    16'h006E: begin batch.slot[n] = mk_data(16'h000A, 1'b0); n = n + 2'd1; end
                    16'h0072: begin batch.slot[n] = mk_data(16'h000D, 1'b0); n = n + 2'd1; end
                    16'h0074: begin batch.slot[n] = mk_data(16'h0009, 1'b0); n = n + 2'd1; end
                    16'h0062: begin batch.slot[n] = mk_data(16'h0008, 1'b0); n = n + 2'd1; end
                    16'h0066: begin batch.slot[n] = mk_data(16'h000C, 1'b0); n = n + 2'd1; end
                    16'h0076: begin batch.slot[n] = mk_data(16'h000B, 1'b0); n = n + 2'd1; end
                    16'h0061: begin batch.slot[n] = mk_data(16'h0007, 1'b0); n = n + 2'd1; end
                    default:
                    begin
                        if (is_oct)
                        begin
                            acc_next = {29'd0, code_unit[2:0]};
                            dc_next  = 4'd1;
                            ph_next  = PH_OCT;
                        end
                        else if (code_unit == 16'h0078)
                            ph_next = PH_HEXSTART;
                        else if (code_unit == 16'h0075 || code_unit == 16'h0055)
                        begin
                            lu_next  = (code_unit == 16'h0055);
                            acc_next = '0;
                            dc_next  = 4'd0;
                            ph_next  = PH_UCN;
                        end
                        else
                        begin
                            batch.slot[n] = mk_data(code_unit, 1'b1);
                            n = n + 2'd1;
                        end
                    end
                endcase
            end
            PH_OCT:
            begin
                if (is_oct)
                begin
                    acc_next = {acc_reg[ACC_BITS-4:0], code_unit[2:0]};
                    dc_next  = dc_reg + 4'd1;
                    if (dc_next >= 4'd3)
                    begin
                        batch.slot[n] = mk_data(acc_next[UNIT_BITS-1:0], 1'b0);
                        n = n + 2'd1;
                        ph_next = PH_LIT;
                    end
                end
                else
                begin
                    batch.slot[n] = mk_data(acc_reg[UNIT_BITS-1:0], 1'b0);
                    n = n + 2'd1;
                    ph_next = lit_ph;
                    if (lit_put)
                    begin
                        batch.slot[n] = mk_data(code_unit, 1'b0);
                        n = n + 2'd1;
                    end
                end
            end
            PH_HEXSTART:
            begin
                if (hx[4])
                begin
                    acc_next = {28'd0, hx[3:0]};
                    ph_next  = PH_HEX;
                end
                else
                begin
                    batch.slot[n] = mk_status(ST_EMPTY_HEX);
                    n = n + 2'd1;
                    ph_next = PH_DONE;
                end
            end
            PH_HEX:
            begin
                if (hx[4])
                    acc_next = {16'd0, acc_reg[UNIT_BITS-5:0], hx[3:0]};
                else
                begin
                    batch.slot[n] = mk_data(acc_reg[UNIT_BITS-1:0], 1'b0);
                    n = n + 2'd1;
                    ph_next = lit_ph;
                    if (lit_put)
                    begin
                        batch.slot[n] = mk_data(code_unit, 1'b0);
                        n = n + 2'd1;
                    end
                end
            end
            PH_UCN:
            begin
                dc_next = dc_reg + 4'd1;
                if (hx[4])
                begin
                    acc_next = {acc_reg[ACC_BITS-5:0], hx[3:0]};
                    ucn_v    = acc_next - 32'h0001_0000;
                    if (dc_next >= need)
                    begin
                        ph_next = PH_LIT;
                        if (acc_next[ACC_BITS-1:UNIT_BITS] == '0)
                        begin
                            batch.slot[n] = mk_data(acc_next[UNIT_BITS-1:0], 1'b0);
                            n = n + 2'd1;
                        end
                        else
                        begin
                            // surrogate pair
                            batch.slot[n] = mk_data(16'hD800 + ucn_v[25:10], 1'b0);
                            n = n + 2'd1;
                            batch.slot[n] = mk_data(16'hDC00 + {6'd0, ucn_v[9:0]}, 1'b0);
                            n = n + 2'd1;
                        end
                    end
                end
                else if (dc_next >= need)
                begin
                    batch.slot[n] = mk_status(ST_BAD_UCN);
                    n = n + 2'd1;
                    ph_next = PH_DONE;
                end
                else
                    ph_next = PH_UCNBAD;
            end
            PH_UCNBAD:
            begin
                dc_next = dc_reg + 4'd1;
                if (dc_next >= need)
                begin
                    batch.slot[n] = mk_status(ST_BAD_UCN);
                    n = n + 2'd1;
                    ph_next = PH_DONE;
                end
            end
            PH_BETWEEN:
            begin
                if (is_q)
                    ph_next = PH_LIT;
                else if (!is_space(code_unit))
                    ph_next = PH_STOPPED;
            end
            default:
            begin
            end
        endcase

        data_put = (n != 2'd0) && !batch.slot[0].is_status;
        emitted  = ea_reg | data_put;
        ea_next  = emitted;

        if (end_of_text)
        begin
            unique case (ph_next)
                PH_SEEK:     begin batch.slot[n] = mk_status(ST_NO_QUOTE); n = n + 2'd1; end
                PH_LIT:      begin batch.slot[n] = mk_status(ST_UNTERM); n = n + 2'd1; end
                PH_ESC:      begin batch.slot[n] = mk_status(ST_END_ESC); n = n + 2'd1; end
                PH_OCT, PH_HEX:
                begin
                    batch.slot[n] = mk_data(acc_next[UNIT_BITS-1:0], 1'b0);
                    n = n + 2'd1;
                    batch.slot[n] = mk_status(ST_UNTERM);
                    n = n + 2'd1;
                end
                PH_HEXSTART: begin batch.slot[n] = mk_status(ST_EMPTY_HEX); n = n + 2'd1; end
                PH_UCN, PH_UCNBAD:
                begin
                    batch.slot[n] = mk_status(ST_SHORT_UCN);
                    n = n + 2'd1;
                end
                PH_BETWEEN, PH_STOPPED:
                begin
                    batch.slot[n] = mk_status((emitted || sqp_next) ? ST_OK : ST_NOTHING);
                    n = n + 2'd1;
                end
                default:
                begin
                end
            endcase
            ph_next  = PH_SEEK;
            acc_next = '0;
            dc_next  = 4'd0;
            lu_next  = 1'b0;
            ea_next  = 1'b0;
            sqp_next = 1'b0;
            pwq_next = 1'b0;
        end

        if (n != 2'd0)
            batch.slot[n - 2'd1].last = 1'b1;
        batch.count = n;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ph_reg  <= PH_SEEK;
            acc_reg <= '0;
            dc_reg  <= 4'd0;
            lu_reg  <= 1'b0;
            ea_reg  <= 1'b0;
            sqp_reg <= 1'b0;
            pwq_reg <= 1'b0;
        end
        else if (fire)
        begin
            ph_reg  <= ph_next;
            acc_reg <= acc_next;
            dc_reg  <= dc_next;
            lu_reg  <= lu_next;
            ea_reg  <= ea_next;
            sqp_reg <= sqp_next;
            pwq_reg <= pwq_next;
        end
    end

endmodule

// ===== sv/csl_obuf.sv =====
// result register bank: holds the results of one item and hands them out one per
// cycle while out_ready is high; depends on csl_pkg

module csl_obuf (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            load,
    input  csl_pkg::batch_t batch,
    output logic            can_load,
    output logic            out_valid,
    input  logic            out_ready,
    output csl_pkg::res_t   head
);
    import csl_pkg::*;

    res_t [MAX_RES-1:0] slot_reg, slot_next;
    logic [1:0]         cnt_reg, cnt_next;
    logic               pop;

    assign out_valid = (cnt_reg != 2'd0);
    assign pop       = out_valid && out_ready;
    assign head      = slot_reg[0];
    // next item may enter while the last pending result leaves
    assign can_load  = (cnt_reg == 2'd0) || (cnt_reg == 2'd1 && out_ready);

    always_comb
    begin
        slot_next = slot_reg;
        cnt_next  = cnt_reg;
        if (pop)
        begin
            slot_next[0] = slot_reg[1];
            slot_next[1] = slot_reg[2];
            cnt_next     = cnt_reg - 2'd1;
        end
        if (load && batch.count != 2'd0)
        begin
            slot_next = batch.slot;
            cnt_next  = batch.count;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= 2'd0;
        else
            cnt_reg <= cnt_next;
    end

    always_ff @(posedge clk)
    begin
        slot_reg <= slot_next;
    end

endmodule

// ===== sv/c_string_literal_unescaper_unit.sv =====
// top level of the c string literal decoder: decode step plus result register bank
// depends on csl_pkg, csl_in_if, csl_out_if, csl_decode, csl_obuf
//
//  port       dir   carries
//  in_item    sink  code_unit[15:0], end_of_text
//  out_item   src   decoded_unit[15:0], unknown_escape, is_status, status[2:0], last_of_item
//
// each code unit is decoded in the cycle it is accepted; its 0 to 3 results are loaded
// into the result bank and leave it one per cycle while the output is ready, starting the next cycle
// a new code unit is taken every cycle while the bank is empty or its last result leaves
// in that cycle; a unit causing more results holds the input while the bank drains
// rst_n clears the parser state and empties the bank; a stalled output holds its item

module c_string_literal_unescaper_unit (
    input  logic      clk,
    input  logic      rst_n,
    csl_in_if.sink    in_item,
    csl_out_if.source out_item
);
    import csl_pkg::*;

    batch_t batch;
    res_t   head;
    logic   can_load;
    logic   fire;

    assign in_item.ready = can_load;
    assign fire          = in_item.valid && can_load;

    csl_decode u_decode (
        .clk         (clk),
        .rst_n       (rst_n),
        .fire        (fire),
        .code_unit   (in_item.code_unit),
        .end_of_text (in_item.end_of_text),
        .batch       (batch)
    );

    csl_obuf u_obuf (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (fire),
        .batch     (batch),
        .can_load  (can_load),
        .out_valid (out_item.valid),
        .out_ready (out_item.ready),
        .head      (head)
    );

    assign out_item.decoded_unit   = head.unit;
    assign out_item.unknown_escape = head.unknown;
    assign out_item.is_status      = head.is_status;
    assign out_item.status         = head.status;
    assign out_item.last_of_item   = head.last;

endmodule

// ===== tb/c_string_literal_unescaper_unit_tb.sv =====
// testbench for c_string_literal_unescaper_unit: string literal texts in, decoded units
// and one status per text out, checked against a built-in decoder model
// depends on csl_pkg, csl_in_if, csl_out_if and the unit itself

module c_string_literal_unescaper_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import csl_pkg::*;

    localparam int CYCLE_LIMIT   = 200000;
    localparam int UNITS_PER_RUN = 430;
    localparam int DRAIN_CYCLES  = 20;

    localparam int SRC_GAP [3]  = '{24, 49, 0};
    localparam int SINK_GAP [3] = '{49, 24, 0};

    localparam unit_t SIMPLE_ESC [9] = '{CH_BSL, CH_QUOTE, "n", "r", "t", "b", "f", "v", "a"};
    localparam unit_t ODD_ESC [8]    = '{"q", "z", "?", "'", "8", "9", "e", "c"};

    class unescape_scoreboard;
        phase_t      phase;
        logic [31:0] acc;
        logic [3:0]  ndig;
        bit          long_ucn;
        bit          emitted_any;
        bit          saw_pair;
        bit          prev_quote;
        res_t        pending[$];
        int          n_checked;
        int          n_status;
        int          n_errors;

        function new();
            clear_parse();
        endfunction

        function void clear_parse();
            phase       = PH_SEEK;
            acc         = '0;
            ndig        = '0;
            long_ucn    = 1'b0;
            emitted_any = 1'b0;
            saw_pair    = 1'b0;
            prev_quote  = 1'b0;
        endfunction

        function void push_data(unit_t u, logic unk);
            res_t r;
            r = '0;
            r.unit = u;
            r.unknown = unk;
            pending.insert(pending.size(), r);
            emitted_any = 1'b1;
        endfunction

        function void push_status(status_t st);
            res_t r;
            r = '0;
            r.is_status = 1'b1;
            r.status = st;
            pending.insert(pending.size(), r);
        endfunction

        function bit hex_nibble(unit_t c, output logic [3:0] v);
            v = 4'd0;
            if (c >= "0" && c <= "9")
                v = c[3:0];
            else if ((c >= "a" && c <= "f") || (c >= "A" && c <= "F"))
                v = c[3:0] + 4'd9;
            else
                return 1'b0;
            return 1'b1;
        endfunction

        // ordinary unit inside a literal
        function void lit_unit(unit_t c);
            phase = PH_LIT;
            if (c == CH_QUOTE)
                phase = PH_BETWEEN;
            else if (c == CH_BSL)
                phase = PH_ESC;
            else
                push_data(c, 1'b0);
        endfunction

        function void take_code_unit(unit_t c, bit eot);
            logic [3:0]  nib;
            logic [3:0]  need;
            logic [31:0] ucn;
            unit_t       hi;
            int          base;
            base = pending.size();
            need = long_ucn ? 4'd8 : 4'd4;
            if (c == CH_QUOTE && prev_quote)
                saw_pair = 1'b1;
            prev_quote = (c == CH_QUOTE);
            case (phase)
                PH_SEEK:
                    if (c == CH_QUOTE)
                        phase = PH_LIT;
                PH_LIT:
                    lit_unit(c);
                PH_ESC:
                begin
                    phase = PH_LIT;
                    case (c)
                        CH_BSL:   push_data(CH_BSL, 1'b0);
                        CH_QUOTE: push_data(CH_QUOTE, 1'b0);
                        "n":      push_data(16'h000A, 1'b0);
                        "r":      push_data(16'h000D, 1'b0);
                        "t":      push_data(16'h0009, 1'b0);
                        "b":      push_data(16'h0008, 1'b0);
                        "f":      push_data(16'h000C, 1'b0);
                        "v":      push_data(16'h000B, 1'b0);
                        "a":      push_data(16'h0007, 1'b0);
                        default:
                        begin
                            if (c >= "0" && c <= "7")
                            begin
                                acc   = {29'd0, c[2:0]};
                                ndig  = 4'd1;
                                phase = PH_OCT;
                            end
                            else if (c == "x")
                                phase = PH_HEXSTART;
                            else if (c == "u" || c == "U")
                            begin
                                long_ucn = (c == "U");
                                acc      = '0;
                                ndig     = '0;
                                phase    = PH_UCN;
                            end
                            else
                                push_data(c, 1'b1);
                        end
                    endcase
                end
                PH_OCT:
                begin
                    if (c >= "0" && c <= "7")
                    begin
                        acc  = {acc[28:0], c[2:0]};
                        ndig = ndig + 4'd1;
                        if (ndig >= 4'd3)
                        begin
                            push_data(acc[15:0], 1'b0);
                            phase = PH_LIT;
                        end
                    end
                    else
                    begin
                        push_data(acc[15:0], 1'b0);
                        lit_unit(c);
                    end
                end
                PH_HEXSTART:
                begin
                    if (hex_nibble(c, nib))
                    begin
                        acc   = {28'd0, nib};
                        phase = PH_HEX;
                    end
                    else
                    begin
                        push_status(ST_EMPTY_HEX);
                        phase = PH_DONE;
                    end
                end
                PH_HEX:
                begin
                    // any number of digits, only the low 16 bits survive
                    if (hex_nibble(c, nib))
                        acc = {16'd0, acc[11:0], nib};
                    else
                    begin
                        push_data(acc[15:0], 1'b0);
                        lit_unit(c);
                    end
                end
                PH_UCN:
                begin
                    ndig = ndig + 4'd1;
                    if (hex_nibble(c, nib))
                    begin
                        acc = {acc[27:0], nib};
                        if (ndig >= need)
                        begin
                            if (acc <= 32'h0000_FFFF)
                                push_data(acc[15:0], 1'b0);
                            else
                            begin
                                // surrogate pair, both halves wrap to 16 bits
                                ucn = acc - 32'h0001_0000;
                                hi  = 16'hD800 + ucn[25:10];
                                push_data(hi, 1'b0);
                                push_data(16'hDC00 + {6'd0, ucn[9:0]}, 1'b0);
                            end
                            phase = PH_LIT;
                        end
                    end
                    else if (ndig >= need)
                    begin
                        push_status(ST_BAD_UCN);
                        phase = PH_DONE;
                    end
                    else
                        phase = PH_UCNBAD;
                end
                PH_UCNBAD:
                begin
                    ndig = ndig + 4'd1;
                    if (ndig >= need)
                    begin
                        push_status(ST_BAD_UCN);
                        phase = PH_DONE;
                    end
                end
                PH_BETWEEN:
                begin
                    if (c == CH_QUOTE)
                        phase = PH_LIT;
                    else if (!(c == 16'h0020 || (c >= 16'h0009 && c <= 16'h000D)))
                        phase = PH_STOPPED;
                end
                default:
                    ;
            endcase

            if (eot)
            begin
                case (phase)
                    PH_SEEK:     push_status(ST_NO_QUOTE);
                    PH_LIT:      push_status(ST_UNTERM);
                    PH_ESC:      push_status(ST_END_ESC);
                    PH_OCT, PH_HEX:
                    begin
                        push_data(acc[15:0], 1'b0);
                        push_status(ST_UNTERM);
                    end
                    PH_HEXSTART: push_status(ST_EMPTY_HEX);
                    PH_UCN, PH_UCNBAD:
                        push_status(ST_SHORT_UCN);
                    PH_BETWEEN, PH_STOPPED:
                        push_status((emitted_any || saw_pair) ? ST_OK : ST_NOTHING);
                    default:
                        ;
                endcase
                clear_parse();
            end

            if (pending.size() > base)
                pending[pending.size() - 1].last = 1'b1;
        endfunction

        function void check_result(res_t got);
            res_t want;
            if (pending.size() == 0)
            begin
                $error("unexpected result: unit %0h is_status %0b status %0d",
                       got.unit, got.is_status, got.status);
                n_errors++;
                return;
            end
            want = pending.pop_front();
            n_checked++;
            if (got.is_status === 1'b1)
                n_status++;
            if (got.unit !== want.unit)
            begin
                $error("decoded_unit: expected %0h, got %0h", want.unit, got.unit);
                n_errors++;
            end
            if (got.unknown !== want.unknown)
            begin
                $error("unknown_escape: expected %0b, got %0b", want.unknown, got.unknown);
                n_errors++;
            end
            if (got.is_status !== want.is_status)
            begin
                $error("is_status: expected %0b, got %0b", want.is_status, got.is_status);
                n_errors++;
            end
            if (got.status !== want.status)
            begin
                $error("status: expected %0d, got %0d", want.status, got.status);
                n_errors++;
            end
            if (got.last !== want.last)
            begin
                $error("last_of_item: expected %0b, got %0b", want.last, got.last);
                n_errors++;
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;

    csl_in_if  in_if();
    csl_out_if out_if();

    c_string_literal_unescaper_unit DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_item  (in_if),
        .out_item (out_if)
    );

    unescape_scoreboard sb;
    unit_t              text_q[$];
    int                 src_gap_pct  = 24;
    int                 sink_gap_pct = 49;
    int                 n_units      = 0;
    int                 n_texts      = 0;
    int                 cycle_count  = 0;

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial
    begin
        out_if.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            out_if.ready <= ($urandom_range(99) >= sink_gap_pct);
        end
    end

    always @(posedge clk)
    begin
        res_t got;
        if (rst_n && out_if.valid === 1'b1 && out_if.ready === 1'b1)
        begin
            got           = '0;
            got.unit      = out_if.decoded_unit;
            got.unknown   = out_if.unknown_escape;
            got.is_status = out_if.is_status;
            got.status    = out_if.status;
            got.last      = out_if.last_of_item;
            sb.check_result(got);
        end
    end

    // adds one code unit to the end of the text being built
    function automatic void append_unit(unit_t u);
        text_q.insert(text_q.size(), u);
    endfunction

    function automatic unit_t rand_hex_char();
        int k;
        k = $urandom_range(21);
        if (k < 10)
            return unit_t'("0") + unit_t'(k);
        else if (k < 16)
            return unit_t'("a") + unit_t'(k - 10);
        return unit_t'("A") + unit_t'(k - 16);
    endfunction

    function automatic unit_t rand_plain();
        unit_t u;
        if ($urandom_range(99) < 80)
            u = unit_t'($urandom_range(16'h0020, 16'h007E));
        else
            u = unit_t'($urandom_range(16'hFFFF));
        if (u == CH_QUOTE || u == CH_BSL)
            u = "g";
        return u;
    endfunction

    function automatic unit_t rand_space();
        int k;
        k = $urandom_range(5);
        return (k == 5) ? 16'h0020 : 16'h0009 + unit_t'(k);
    endfunction

    // starts and ends at a falling edge
    task automatic send_unit(unit_t u, logic eot);
        while ($urandom_range(99) < src_gap_pct)
        begin
            in_if.valid <= 1'b0;
            @(negedge clk);
        end
        in_if.valid       <= 1'b1;
        in_if.code_unit   <= u;
        in_if.end_of_text <= eot;
        do
            @(posedge clk);
        while (in_if.ready !== 1'b1);
        sb.take_code_unit(u, eot);
        n_units++;
        @(negedge clk);
    endtask

    task automatic send_text();
        for (int i = 0; i < text_q.size(); i++)
            send_unit(text_q[i], i == text_q.size() - 1);
        n_texts++;
    endtask

    task automatic send_string(string s);
        text_q.delete();
        for (int i = 0; i < s.len(); i++)
            append_unit(unit_t'(s[i]));
        send_text();
    endtask

    task automatic make_random_text();
        int nlit;
        int tok;
        int k;
        int ending;
        text_q.delete();
        // pure noise, may or may not hold a quote
        if ($urandom_range(99) < 6)
        begin
            repeat ($urandom_range(1, 4))
                append_unit(unit_t'($urandom_range(16'hFFFF)));
            return;
        end
        if ($urandom_range(99) < 30)
            repeat ($urandom_range(1, 3))
                append_unit(rand_plain());
        append_unit(CH_QUOTE);
        nlit = $urandom_range(1, 2);
        for (int i = 0; i < nlit; i++)
        begin
            repeat ($urandom_range(0, 5))
            begin
                tok = $urandom_range(99);
                if (tok < 30)
                    append_unit(rand_plain());
                else
                begin
                    append_unit(CH_BSL);
                    if (tok < 45)
                        append_unit(SIMPLE_ESC[$urandom_range(8)]);
                    else if (tok < 55)
                        repeat ($urandom_range(1, 3))
                            append_unit(unit_t'("0") + unit_t'($urandom_range(7)));
                    else if (tok < 65)
                    begin
                        append_unit("x");
                        repeat ($urandom_range(1, 6))
                            append_unit(rand_hex_char());
                    end
                    else if (tok < 73)
                    begin
                        append_unit("u");
                        repeat (4)
                            append_unit(rand_hex_char());
                    end
                    else if (tok < 79)
                    begin
                        append_unit("U");
                        // leading zeros, in half the cases, keep the value near the surrogate range
                        k = $urandom_range(1) ? 3 : 0;
                        repeat (k)
                            append_unit("0");
                        repeat (8 - k)
                            append_unit(rand_hex_char());
                    end
                    else if (tok < 86)
                    begin
                        if ($urandom_range(1))
                            append_unit(ODD_ESC[$urandom_range(7)]);
                        else
                            append_unit(unit_t'($urandom_range(16'h0080, 16'hFFFF)));
                    end
                    else if (tok < 90)
                    begin
                        append_unit("x");
                        append_unit("g");
                    end
                    else
                    begin
                        append_unit($urandom_range(1) ? unit_t'("u") : unit_t'("U"));
                        k = $urandom_range(3);
                        repeat (k)
                            append_unit(rand_hex_char());
                        append_unit("z");
                        repeat (3 - k)
                            append_unit(rand_hex_char());
                    end
                end
            end
            if (i < nlit - 1)
            begin
                append_unit(CH_QUOTE);
                repeat ($urandom_range(0, 2))
                    append_unit(rand_space());
                append_unit(CH_QUOTE);
            end
        end
        ending = $urandom_range(99);
        if (ending < 55)
        begin
            append_unit(CH_QUOTE);
            if ($urandom_range(99) < 35)
            begin
                repeat ($urandom_range(0, 2))
                    append_unit(rand_space());
                append_unit(rand_plain());
                repeat ($urandom_range(0, 2))
                    append_unit(unit_t'($urandom_range(16'hFFFF)));
            end
        end
        else if (ending < 75)
        begin
            // unterminated, often with an octal or hex escape still open
            if ($urandom_range(1))
            begin
                append_unit(CH_BSL);
                if ($urandom_range(1))
                    append_unit(unit_t'("0") + unit_t'($urandom_range(7)));
                else
                begin
                    append_unit("x");
                    append_unit(rand_hex_char());
                end
            end
        end
        else if (ending < 85)
            append_unit(CH_BSL);
        else if (ending < 93)
        begin
            append_unit(CH_BSL);
            append_unit("x");
        end
        else
        begin
            append_unit(CH_BSL);
            append_unit($urandom_range(1) ? unit_t'("u") : unit_t'("U"));
            repeat ($urandom_range(0, 3))
                append_unit(rand_hex_char());
        end
    endtask

    initial
    begin
        int target;
        sb                = new();
        rst_n             = 1'b0;
        in_if.valid       = 1'b0;
        in_if.code_unit   = '0;
        in_if.end_of_text = 1'b0;
        repeat (6)
            @(negedge clk);
        rst_n <= 1'b1;

        for (int ph = 0; ph < 3; ph++)
        begin
            src_gap_pct  = SRC_GAP[ph];
            sink_gap_pct = SINK_GAP[ph];
            target = (UNITS_PER_RUN * (ph + 1)) / 3;
            if (ph == 0)
            begin
                send_string("z");
                send_string("\"\"");
                send_string("\"\\x");
                send_string("\"\\xg\"");
                send_string("\"\\");
                // surrogate pair and the unterminated status from one unit
                send_string("\"\\U0001F600");
                text_q = '{CH_QUOTE, 16'hFFFF, 16'h0000};
                send_text();
            end
            while (n_units < target)
            begin
                make_random_text();
                send_text();
            end
        end

        in_if.valid  <= 1'b0;
        sink_gap_pct = 0;
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES)
            @(posedge clk);

        $display("sent %0d texts as %0d code units under three idle patterns",
                 n_texts, n_units);
        $display("compared %0d results, %0d of them status results",
                 sb.n_checked, sb.n_status);
        if (sb.n_errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ===== c_string_literal_unescaper_unit.f =====
sv/csl_pkg.sv
sv/csl_in_if.sv
sv/csl_out_if.sv
sv/csl_decode.sv
sv/csl_obuf.sv
sv/c_string_literal_unescaper_unit.sv
tb/c_string_literal_unescaper_unit_tb.sv
